// ===== rtl/core/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

  // Configuration port layout: two 64-bit registers at byte addresses 0 and 8.
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_ADDR_EXPONENT = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] REG_ADDR_MODULUS  = 4'h8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_WRITE
  } mexp_state_e;

endpackage

`default_nettype wire

// ===== rtl/core/mexp_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mexp_regs (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [mexp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [mexp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [mexp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                      pready,
  output logic      [mexp_pkg::CFG_DATA_W-1:0]      exponent_o,
  output logic      [mexp_pkg::CFG_DATA_W-1:0]      modulus_o
);
  import mexp_pkg::*;

  logic [CFG_DATA_W-1:0] exponent_q;
  logic [CFG_DATA_W-1:0] modulus_q;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= '0;
      modulus_q  <= '0;
    end else if (wr_en) begin
      if (paddr == REG_ADDR_EXPONENT) begin
        exponent_q <= pwdata;
      end
      if (paddr == REG_ADDR_MODULUS) begin
        modulus_q <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_ADDR_EXPONENT) begin
      prdata = exponent_q;
    end else if (paddr == REG_ADDR_MODULUS) begin
      prdata = modulus_q;
    end
  end

  assign exponent_o = exponent_q;
  assign modulus_o  = modulus_q;

endmodule

`default_nettype wire

// ===== rtl/core/mexp_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial modular multiplier: r = a * b mod n, scanning b from its top bit,
// one doubling and conditional add per cycle. Needs a < n and n >= 2.
module mexp_mulmod #(
  parameter int unsigned WORD_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [WORD_WIDTH-1:0] a_i,
  input  wire logic [WORD_WIDTH-1:0] b_i,
  input  wire logic [WORD_WIDTH-1:0] n_i,
  output logic                       done_o,
  output logic      [WORD_WIDTH-1:0] result_o
);
  localparam int unsigned CntW = $clog2(WORD_WIDTH);

  logic [WORD_WIDTH-1:0] r_q, a_q, b_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q, done_q;

  logic [WORD_WIDTH:0]   dbl;
  logic [WORD_WIDTH+1:0] sum;
  logic [WORD_WIDTH+2:0] sub1, sub2;
  logic [WORD_WIDTH-1:0] step;

  // 2r + a stays below 3n, so one of three candidates is the reduced value.
  always_comb begin
    dbl  = {r_q, 1'b0};
    sum  = {1'b0, dbl} + (b_q[WORD_WIDTH-1] ? {2'b00, a_q} : '0);
    sub1 = {1'b0, sum} - {3'b000, n_i};
    sub2 = {1'b0, sum} - {2'b00, n_i, 1'b0};
    if (!sub2[WORD_WIDTH+2]) begin
      step = sub2[WORD_WIDTH-1:0];
    end else if (!sub1[WORD_WIDTH+2]) begin
      step = sub1[WORD_WIDTH-1:0];
    end else begin
      step = sum[WORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(WORD_WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q <= '0;
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      r_q <= step;
      b_q <= {b_q[WORD_WIDTH-2:0], 1'b0};
    end
  end

  assign done_o   = done_q;
  assign result_o = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A modulus of 0 or 1 skips the multiplier and goes straight to the output register.
// Every modular product runs through the one bit-serial multiplier, one multiplier bit a cycle.
// One item is worked at a time; the next is taken once the result moves to the output register.
// Reset (asynchronous, active low) clears the key registers to 0 and empties the block.
module modular_exponentiation #(
  parameter int unsigned WORD_WIDTH = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [mexp_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [mexp_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [mexp_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                      pready,
  input  wire logic                                 base_valid_i,
  output logic                                      base_ready_o,
  input  wire logic [WORD_WIDTH-1:0]                base_i,
  output logic                                      result_valid_o,
  input  wire logic                                 result_ready_i,
  output logic      [WORD_WIDTH-1:0]                power_result_o,
  output logic                                      modulus_invalid_o
);
  import mexp_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_WIDTH);

  logic [CFG_DATA_W-1:0] exponent, modulus;
  logic [WORD_WIDTH-1:0] n_in;

  mexp_state_e state_q, state_d;
  logic        start_q, start_d;
  logic        accept, n_small, out_free;

  logic [WORD_WIDTH-1:0] n_q, e_q, base_q, r_q;
  logic                  inv_q;
  logic [CntW-1:0]       bit_cnt_q;

  logic [WORD_WIDTH-1:0] mm_a, mm_b, mm_result;
  logic                  mm_done;

  logic                  out_valid_q;
  logic [WORD_WIDTH-1:0] out_result_q;
  logic                  out_inv_q;

  mexp_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .exponent_o (exponent),
    .modulus_o  (modulus)
  );

  mexp_mulmod #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .a_i      (mm_a),
    .b_i      (mm_b),
    .n_i      (n_q),
    .done_o   (mm_done),
    .result_o (mm_result)
  );

  assign n_in     = modulus[WORD_WIDTH-1:0];
  assign n_small  = (n_in[WORD_WIDTH-1:1] == '0);
  assign accept   = base_valid_i && base_ready_o;
  assign out_free = !out_valid_q || result_ready_i;

  // Operand selection for the multiplier; the base reduction is 1 * base mod n.
  always_comb begin
    unique case (state_q)
      ST_REDUCE: begin
        mm_a = WORD_WIDTH'(1);
        mm_b = base_q;
      end
      ST_MULT: begin
        mm_a = base_q;
        mm_b = r_q;
      end
      default: begin
        mm_a = r_q;
        mm_b = r_q;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    start_d      = 1'b0;
    base_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (base_valid_i) begin
          if (n_small) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_REDUCE;
            start_d = 1'b1;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          state_d = ST_SQUARE;
          start_d = 1'b1;
        end
      end
      ST_SQUARE: begin
        if (mm_done) begin
          if (e_q[WORD_WIDTH-1]) begin
            state_d = ST_MULT;
            start_d = 1'b1;
          end else if (bit_cnt_q == '0) begin
            state_d = ST_WRITE;
          end else begin
            start_d = 1'b1;
          end
        end
      end
      ST_MULT: begin
        if (mm_done) begin
          if (bit_cnt_q == '0) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_SQUARE;
            start_d = 1'b1;
          end
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      if (state_q == ST_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The exponent is consumed from its top bit; it shifts once per exponent bit.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_q       <= n_in;
      e_q       <= exponent[WORD_WIDTH-1:0];
      base_q    <= base_i;
      r_q       <= n_small ? '0 : WORD_WIDTH'(1);
      inv_q     <= n_small;
      bit_cnt_q <= CntW'(WORD_WIDTH - 1);
    end else if (mm_done) begin
      if (state_q == ST_REDUCE) begin
        base_q <= mm_result;
      end else begin
        r_q <= mm_result;
        if (state_q == ST_MULT || !e_q[WORD_WIDTH-1]) begin
          e_q       <= {e_q[WORD_WIDTH-2:0], 1'b0};
          bit_cnt_q <= bit_cnt_q - 1'b1;
        end
      end
    end
    if (state_q == ST_WRITE && out_free) begin
      out_result_q <= r_q;
      out_inv_q    <= inv_q;
    end
  end

  assign result_valid_o    = out_valid_q;
  assign power_result_o    = out_result_q;
  assign modulus_invalid_o = out_inv_q;

endmodule

`default_nettype wire
